// ----- design/bmc_pkg.sv -----
// Shared types and constants for the block mode color core.
// Depends on nothing; every other design file imports it.
package bmc_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 3 * CHAN_W;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned MODE_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 7'd127;

  // Area modes held in the configuration register.
  localparam logic [MODE_W-1:0] MODE_SUBSAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROW       = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COLUMN    = 2'd3;

  localparam logic [CHAN_W-1:0] CHAN_FULL   = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_WHITE  = 8'd254;
  localparam logic [CHAN_W-1:0] LIFT_SMALL  = 8'd1;
  localparam logic [CHAN_W-1:0] LIFT_LARGE  = 8'd10;

  // Queue between the front and the back part.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic              last_in_area;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  mode_red;
    logic [CHAN_W-1:0]  mode_green;
    logic [CHAN_W-1:0]  mode_blue;
    logic [COUNT_W-1:0] mode_count;
    logic               area_overflow;
  } result_t;

  // One classified pixel as handed from the front to the back part.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               counted;
    logic               last;
    logic               ovf;
  } job_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_SCAN,
    BK_EMIT
  } back_state_t;

endpackage

// ----- design/bmc_front.sv -----
// Front part: holds the area mode register, adjusts and classifies pixels.
// Depends on bmc_pkg.
module bmc_front import bmc_pkg::*; #(
  parameter int unsigned AREA_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  pixel_t            pix,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data,
  output logic              job_valid,
  input  logic              job_full,
  output job_t              job
);

  localparam int unsigned CNT_W = $clog2(AREA_MAX + 1);

  logic [MODE_W-1:0] area_mode;
  logic [CNT_W-1:0]  pixels_seen;
  logic              overflow_seen;
  logic              accept;
  logic              counted;
  logic              is_black;
  logic              is_white;
  logic [CHAN_W-1:0] lift;
  logic [CHAN_W-1:0] r;
  logic [CHAN_W-1:0] g;
  logic [CHAN_W-1:0] b;

  assign cfg_ready = 1'b1;
  assign pix_stall = job_full;
  assign accept    = pix_valid & ~job_full;

  always_comb begin
    is_black = (pix.red_in == '0) && (pix.green_in == '0) && (pix.blue_in == '0);
    is_white = (pix.red_in == CHAN_FULL) && (pix.green_in == CHAN_FULL) &&
               (pix.blue_in == CHAN_FULL);
    lift = ((area_mode == MODE_ROW) || (area_mode == MODE_COLUMN)) ? LIFT_LARGE : LIFT_SMALL;
    r = pix.red_in;
    g = pix.green_in;
    b = pix.blue_in;
    if (is_black) begin
      r = lift;
      g = lift;
      b = lift;
    end else if (is_white) begin
      r = CHAN_WHITE;
      g = CHAN_WHITE;
      b = CHAN_WHITE;
    end
    counted = pixels_seen < CNT_W'(AREA_MAX);
  end

  assign job_valid   = pix_valid;
  assign job.color   = {r, g, b};
  assign job.counted = counted;
  assign job.last    = pix.last_in_area;
  assign job.ovf     = overflow_seen | ~counted;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_mode     <= MODE_SUBSAMPLE;
      pixels_seen   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        area_mode <= cfg_data;
      end
      if (accept) begin
        if (pix.last_in_area) begin
          pixels_seen   <= '0;
          overflow_seen <= 1'b0;
        end else if (counted) begin
          pixels_seen <= pixels_seen + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/bmc_queue.sv -----
// Short word queue that decouples the front part from the table back part.
// Depends on bmc_pkg.
module bmc_queue import bmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_word,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_word
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign full      = fill == (QPTR_W + 1)'(QDEPTH);
  assign pop_valid = fill != '0;
  assign pop_word  = slots[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ----- design/bmc_back.sv -----
// Back part: distinct-color table in a memory, sequential search and
// maximum scan, and the result output register. Depends on bmc_pkg.
module bmc_back import bmc_pkg::*; #(
  parameter int unsigned AREA_MAX = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_pop,
  input  job_t    job,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  localparam int unsigned CNT_W = $clog2(AREA_MAX + 1);
  localparam int unsigned IDX_W = (AREA_MAX > 1) ? $clog2(AREA_MAX) : 1;

  entry_t tbl [AREA_MAX];
  entry_t rdata;

  back_state_t        state, state_next;
  job_t               cur, cur_next;
  logic [CNT_W-1:0]   entries, entries_next;
  logic [CNT_W-1:0]   issue, issue_next;
  logic               chk_vld, chk_vld_next;
  logic [IDX_W-1:0]   chk_idx, chk_idx_next;
  logic [COLOR_W-1:0] best_color, best_color_next;
  logic [COUNT_W-1:0] best_count, best_count_next;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               res_load;
  logic               issue_done;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= tbl[rd_addr];
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    entries_next    = entries;
    issue_next      = issue;
    chk_vld_next    = 1'b0;
    chk_idx_next    = issue[IDX_W-1:0];
    best_color_next = best_color;
    best_count_next = best_count;
    rd_en           = 1'b0;
    rd_addr         = issue[IDX_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = chk_idx;
    wr_data         = rdata;
    job_pop         = 1'b0;
    res_load        = 1'b0;
    issue_done      = issue == entries;

    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop         = 1'b1;
          cur_next        = job;
          issue_next      = '0;
          best_color_next = '0;
          best_count_next = '0;
          if (job.counted) begin
            state_next = BK_SEARCH;
          end else if (job.last) begin
            state_next = BK_SCAN;
          end
        end
      end
      BK_SEARCH: begin
        if (chk_vld && (rdata.color == cur.color)) begin
          // Known color: bump its count, saturating.
          wr_en         = 1'b1;
          wr_addr       = chk_idx;
          wr_data.color = rdata.color;
          wr_data.count = (rdata.count < COUNT_SAT) ? rdata.count + COUNT_W'(1)
                                                     : rdata.count;
          issue_next    = '0;
          state_next    = cur.last ? BK_SCAN : BK_IDLE;
        end else if (issue_done && !chk_vld) begin
          // New color: append it with a count of one.
          wr_en         = 1'b1;
          wr_addr       = entries[IDX_W-1:0];
          wr_data.color = cur.color;
          wr_data.count = COUNT_W'(1);
          entries_next  = entries + CNT_W'(1);
          issue_next    = '0;
          state_next    = cur.last ? BK_SCAN : BK_IDLE;
        end else if (!issue_done) begin
          rd_en        = 1'b1;
          issue_next   = issue + CNT_W'(1);
          chk_vld_next = 1'b1;
        end
      end
      BK_SCAN: begin
        if (chk_vld && (rdata.count > best_count)) begin
          best_count_next = rdata.count;
          best_color_next = rdata.color;
        end
        if (issue_done && !chk_vld) begin
          state_next = BK_EMIT;
        end else if (!issue_done) begin
          rd_en        = 1'b1;
          issue_next   = issue + CNT_W'(1);
          chk_vld_next = 1'b1;
        end
      end
      BK_EMIT: begin
        if (!res_valid || !res_stall) begin
          res_load     = 1'b1;
          entries_next = '0;
          state_next   = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      entries   <= '0;
      issue     <= '0;
      chk_vld   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      entries <= entries_next;
      issue   <= issue_next;
      chk_vld <= chk_vld_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    chk_idx    <= chk_idx_next;
    best_color <= best_color_next;
    best_count <= best_count_next;
    if (res_load) begin
      res.mode_red      <= best_color[COLOR_W-1 -: CHAN_W];
      res.mode_green    <= best_color[CHAN_W +: CHAN_W];
      res.mode_blue     <= best_color[CHAN_W-1:0];
      res.mode_count    <= best_count;
      res.area_overflow <= cur.ovf;
    end
  end

endmodule

// ----- design/block_mode_color_core.sv -----
// Top level of the block mode color core: front part, word queue, back part.
// Depends on bmc_pkg, bmc_front, bmc_queue and bmc_back.
//
// The core finds the dominant color of one image area. Pixels arrive one
// word at a time on the pix channel; the word with last_in_area set closes
// the area and then one result word leaves on the res
// channel with the most frequent adjusted color, its count, and a flag
// that is set when the area held more than AREA_MAX pixels (the extra
// pixels are not counted). Pure white is counted as 254,254,254 and pure
// black as 1,1,1 in area mode 1 (and mode 0) or 10,10,10 in modes 2 and 3.
// On a tie the color that appeared first in the area wins. The area mode
// is written through the cfg channel, which is always ready; write it only
// while the core is idle. Timing: the front part takes a pixel word every
// cycle while its four-word queue has room. The back part walks the color
// table one entry per cycle through a single registered memory read port.
// For a counted pixel it takes the word from the queue, reads up to N
// entries, N being the number of distinct colors seen so far in the area
// (below AREA_MAX), makes one last compare and writes the table; the
// closing pixel adds a full scan of the table and the load of the result
// register. The back part takes the next pixel word from the queue only
// once it is done with the last one. The table needs no clearing pass after reset.
module block_mode_color_core import bmc_pkg::*; #(
  parameter int unsigned AREA_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  pixel_t            pix,
  output logic              res_valid,
  input  logic              res_stall,
  output result_t           res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data
);

  // Front to queue.
  logic job_push;
  logic q_full;
  job_t front_job;

  // Queue to back.
  logic q_valid;
  logic q_pop;
  job_t q_job;

  bmc_front #(
    .AREA_MAX (AREA_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (job_push),
    .job_full  (q_full),
    .job       (front_job)
  );

  bmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_word (front_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_word  (q_job)
  );

  // The back part owns the table memory and the result register.
  bmc_back #(
    .AREA_MAX (AREA_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job       (q_job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ----- bench/bmc_checker.sv -----
// Checker for the block mode color core: watches the pixel, result and mode channels.
// Depends on bmc_pkg; keeps its own model of the color tally and counts mismatches.
module bmc_checker import bmc_pkg::*; #(
  parameter int unsigned AREA_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  input  logic              pix_stall,
  input  pixel_t            pix,
  input  logic              res_valid,
  input  logic              res_stall,
  input  result_t           res,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data,
  output int                mismatches,
  output int                due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COLOR_W-1:0] color_tab [AREA_MAX];
  logic [COUNT_W-1:0] count_tab [AREA_MAX];
  int unsigned        colors_used;
  int unsigned        pixels_counted;
  logic               area_spilled;
  logic [MODE_W-1:0]  area_mode;
  result_t            results_due [$];
  result_t            want;
  logic [COLOR_W-1:0] seen_color;

  task automatic report(input string what);
    $display("[%0t ns] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int exp);
    if (got != exp) begin
      report($sformatf("%s is %0d, expected %0d", name, got, exp));
    end
  endtask

  // White is pulled down to 254 and black lifted by an amount that depends on the mode.
  function automatic logic [COLOR_W-1:0] adjusted_color(input pixel_t p,
                                                        input logic [MODE_W-1:0] m);
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] lift;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    if (r == '0 && g == '0 && b == '0) begin
      lift = (m == MODE_ROW || m == MODE_COLUMN) ? LIFT_LARGE : LIFT_SMALL;
      r = lift;
      g = lift;
      b = lift;
    end
    if (r == CHAN_FULL && g == CHAN_FULL && b == CHAN_FULL) begin
      r = CHAN_WHITE;
      g = CHAN_WHITE;
      b = CHAN_WHITE;
    end
    return {r, g, b};
  endfunction

  task automatic tally(input logic [COLOR_W-1:0] c);
    bit found;
    found = 1'b0;
    for (int i = 0; i < colors_used; i++) begin
      if (!found && color_tab[i] == c) begin
        found = 1'b1;
        if (count_tab[i] != COUNT_SAT) count_tab[i]++;
      end
    end
    if (!found && colors_used < AREA_MAX) begin
      color_tab[colors_used] = c;
      count_tab[colors_used] = COUNT_W'(1);
      colors_used++;
    end
  endtask

  // Strictly greater keeps the earliest color on a tie.
  function automatic result_t dominant();
    result_t            r;
    logic [COLOR_W-1:0] best_color;
    logic [COUNT_W-1:0] best_count;
    best_color = '0;
    best_count = '0;
    for (int i = 0; i < colors_used; i++) begin
      if (count_tab[i] > best_count) begin
        best_count = count_tab[i];
        best_color = color_tab[i];
      end
    end
    r.mode_red      = best_color[23:16];
    r.mode_green    = best_color[15:8];
    r.mode_blue     = best_color[7:0];
    r.mode_count    = best_count;
    r.area_overflow = area_spilled;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mismatches     = 0;
      colors_used    = 0;
      pixels_counted = 0;
      area_spilled   = 1'b0;
      area_mode      = MODE_SUBSAMPLE;
      results_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (results_due.size() == 0) begin
          report("result word arrived with no area closed");
        end else begin
          want = results_due.pop_front();
          check_field("mode_red", res.mode_red, want.mode_red);
          check_field("mode_green", res.mode_green, want.mode_green);
          check_field("mode_blue", res.mode_blue, want.mode_blue);
          check_field("mode_count", res.mode_count, want.mode_count);
          check_field("area_overflow", res.area_overflow, want.area_overflow);
        end
      end
      if (cfg_valid && cfg_ready) area_mode = cfg_data;
      if (pix_valid && !pix_stall) begin
        seen_color = adjusted_color(pix, area_mode);
        if (pixels_counted < AREA_MAX) begin
          tally(seen_color);
          pixels_counted++;
        end else begin
          area_spilled = 1'b1;
        end
        if (pix.last_in_area) begin
          results_due    = {results_due, dominant()};
          colors_used    = 0;
          pixels_counted = 0;
          area_spilled   = 1'b0;
        end
      end
    end
    due_count <= results_due.size();
  end

endmodule

// ----- bench/tb_block_mode_color_core.sv -----
// Testbench top for the block mode color core: clock, reset, stimulus and verdict.
// Depends on bmc_pkg, block_mode_color_core and the bmc_checker module in this folder.
module tb_block_mode_color_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bmc_pkg::*;

  localparam int unsigned AREA_MAX = 64;

  // Mode zero is legal on the port and behaves like the subsample mode.
  localparam logic [MODE_W-1:0] MODE_UNSET = 2'd0;

  // A closing pixel may need a search and a full scan of the table before its
  // result word is loaded, so this is how long we let the core settle.
  localparam int unsigned SETTLE_CYCLES = 2 * AREA_MAX + 24;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              pix_valid = 1'b0;
  pixel_t            pix       = '0;
  logic              res_stall = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [MODE_W-1:0] cfg_data  = '0;
  logic              pix_stall;
  logic              res_valid;
  logic              cfg_ready;
  result_t           res;

  // While calm is set neither side idles, giving one long back-to-back stretch.
  bit                calm = 1'b0;
  int                mismatches;
  int                due_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  block_mode_color_core #(
    .AREA_MAX(AREA_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  bmc_checker #(
    .AREA_MAX(AREA_MAX)
  ) checker_inst (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .due_count (due_count)
  );

  // The result side stalls about a third of the time, except in the calm stretch.
  always @(posedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < 33);
  end

  // Offers one pixel word, possibly after a few idle cycles, and returns at the
  // edge where it was taken. The payload holds still while the core stalls, and
  // valid is lowered only when the next call decides to idle or settle() runs.
  task automatic send_pixel(input pixel_t p);
    while (!calm && $urandom_range(0, 99) < 33) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic put(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                     input logic [CHAN_W-1:0] b, input logic last);
    send_pixel({r, g, b, last});
  endtask

  // Drops pixel valid and waits until every closed area has delivered its word.
  // The first edge lets the expectation from the final pixel show up in the
  // count before it is polled; after that the core is given time to go quiet.
  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the core is idle.
  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random colors lean on the special values so that the white and black
  // adjustments and their merges with the already adjusted colors come up often.
  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return {3{CHAN_FULL}};
    if (roll < 25) return {3{LIFT_SMALL}};
    if (roll < 30) return {3{LIFT_LARGE}};
    if (roll < 35) return {3{CHAN_WHITE}};
    return COLOR_W'($urandom());
  endfunction

  // One well-formed area: a small palette makes repeats and ties likely, and a
  // quarter of the pixels are fresh colors that grow the table.
  task automatic random_area(input int unsigned len);
    logic [COLOR_W-1:0] palette [4];
    logic [COLOR_W-1:0] c;
    for (int k = 0; k < 4; k++) palette[k] = pick_color();
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) != 0) c = palette[$urandom_range(0, 3)];
      else c = COLOR_W'($urandom());
      send_pixel({c, (i == len - 1)});
    end
  endtask

  // Most areas are short to keep the run brisk; some sit right at the table
  // size and a few run well past it so that the overflow flag gets exercised.
  function automatic int unsigned area_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return $urandom_range(1, 8);
    if (roll < 85) return $urandom_range(9, 40);
    if (roll < 94) return $urandom_range(AREA_MAX - 1, AREA_MAX + 2);
    return $urandom_range(AREA_MAX + 3, AREA_MAX + 16);
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    int unsigned       sent;
    int unsigned       len;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed areas in the subsample mode.
    write_mode(MODE_SUBSAMPLE);
    put(8'd255, 8'd255, 8'd255, 1'b1);           // lone white comes back as 254
    put(8'd0,   8'd0,   8'd0,   1'b1);           // lone black lifted to 1
    put(8'd255, 8'd255, 8'd254, 1'b0);           // near white and near black are
    put(8'd0,   8'd0,   8'd1,   1'b0);           // left untouched
    put(8'd0,   8'd0,   8'd1,   1'b1);
    put(8'd12,  8'd34,  8'd56,  1'b0);           // two colors tie at two each;
    put(8'd200, 8'd100, 8'd50,  1'b0);           // the one seen first must win
    put(8'd200, 8'd100, 8'd50,  1'b0);
    put(8'd12,  8'd34,  8'd56,  1'b1);
    put(8'd255, 8'd255, 8'd255, 1'b0);           // adjusted white merges with 254
    put(8'd254, 8'd254, 8'd254, 1'b0);
    put(8'd1,   8'd2,   8'd3,   1'b1);
    put(8'd0,   8'd0,   8'd0,   1'b0);           // lifted black merges with 1,1,1
    put(8'd1,   8'd1,   8'd1,   1'b1);

    // Mode zero lifts black by one, like the subsample mode.
    settle();
    write_mode(MODE_UNSET);
    put(8'd0,   8'd0,   8'd0,   1'b0);
    put(8'd10,  8'd10,  8'd10,  1'b0);
    put(8'd1,   8'd1,   8'd1,   1'b1);

    // The row and column modes lift black by ten.
    settle();
    write_mode(MODE_ROW);
    put(8'd0,   8'd0,   8'd0,   1'b0);
    put(8'd1,   8'd1,   8'd1,   1'b0);
    put(8'd10,  8'd10,  8'd10,  1'b1);
    put(8'd255, 8'd255, 8'd255, 1'b1);
    settle();
    write_mode(MODE_COLUMN);
    put(8'd0,   8'd0,   8'd0,   1'b1);
    put(8'd255, 8'd0,   8'd255, 1'b0);
    put(8'd0,   8'd255, 8'd0,   1'b1);

    // Random phases, each under its own mode. The first four walk through every
    // mode value; one of them runs without any idling on either side.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       mode = MODE_COLUMN;
        1:       mode = MODE_UNSET;
        2:       mode = MODE_SUBSAMPLE;
        3:       mode = MODE_ROW;
        default: mode = MODE_W'($urandom_range(0, 3));
      endcase
      calm <= (phase == 3);
      write_mode(mode);
      sent = 0;
      while (sent < 40) begin
        len = area_length();
        random_area(len);
        sent += len;
      end
    end

    settle();
    calm <= 1'b0;
    if (mismatches == 0 && due_count == 0) begin
      $display("** block_mode_color_core: PASSED **");
    end else begin
      $display("** block_mode_color_core: FAILED **");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("** block_mode_color_core: FAILED **");
    $finish;
  end

endmodule
